/* rtl/core/kfve_pkg.sv */
// Shared types, constants and helpers for the keyed field version extractor.
`default_nettype none

package kfve_pkg;

    localparam int unsigned VERSION_BUFFER_DEF = 64;
    localparam int unsigned HEADER_BYTES       = 20;

    localparam logic [15:0] HDR_LEN      = 16'(HEADER_BYTES);
    localparam logic [15:0] HDR_LAST_POS = 16'(HEADER_BYTES - 1);
    localparam logic [15:0] LEN_HI_POS   = 16'd8;
    localparam logic [15:0] LEN_LO_POS   = 16'd9;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    localparam logic [7:0] SEP_HI = 8'hC0;
    localparam logic [7:0] SEP_LO = 8'h80;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    typedef enum logic [1:0] {
        VERDICT_SUCCESS    = 2'd0,
        VERDICT_IN_PROCESS = 2'd1,
        VERDICT_REJECT     = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] packet_length;
        logic        from_initiator;
        logic        last_byte;
    } item_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] version_byte;
        verdict_t   verdict;
        logic       packet_done;
    } result_t;

    // Up to two results per byte, packed in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    // Key prefix "135".
    function automatic logic [7:0] key_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h31;
            2'd1:    c = 8'h33;
            2'd2:    c = 8'h35;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/kfve_if.sv */
// Valid/ready channel interfaces for packet bytes and results.
`default_nettype none

interface kfve_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        from_initiator;
    logic        last_byte;

    modport source (output valid, data_byte, packet_length, from_initiator, last_byte,
                    input ready);
    modport sink   (input valid, data_byte, packet_length, from_initiator, last_byte,
                    output ready);
endinterface

interface kfve_result_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] version_byte;
    logic [1:0] verdict;
    logic       packet_done;

    modport source (output valid, is_status, version_byte, verdict, packet_done,
                    input ready);
    modport sink   (input valid, is_status, version_byte, verdict, packet_done,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/keyed_field_version_extractor.sv */
// Top level of the keyed field version extractor.
`default_nettype none

// Takes one packet byte per transfer on pkt and emits results on res. A
// packet from the initiator with a length of at least the header size and a
// big-endian length word at bytes 8-9 equal to the length minus the header
// size is parsed for key/value fields ended by 0xC0 0x80; the value of the
// first key that starts with "135" (after two skipped bytes, up to
// VERSION_BUFFER-1 bytes, never the final packet byte) streams out as
// version-byte results (is_status = 0). On the last byte one verdict result
// (is_status = 1, packet_done = 1) follows: success, in process, or
// rejected. Rate: one byte per cycle sustained while res is not stalled;
// each byte is held in the input register and parsed as it leaves it, and
// its results are written into the result queue, from which they transfer
// on res. Results go through a four-entry queue that delivers one per cycle
// while res.ready is high; pkt.ready drops only while that queue has fewer
// than two free entries, which happens when res is stalled.
module keyed_field_version_extractor
    import kfve_pkg::*;
#(
    parameter int unsigned VERSION_BUFFER = VERSION_BUFFER_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    kfve_byte_if.sink      pkt,
    kfve_result_if.source  res
);

    // input register
    logic         stage_valid_reg;
    item_t        stage_item_reg;
    logic         advance;
    logic         room2;
    result_pair_t pair;
    result_t      head;

    // a held byte moves on only when the queue can absorb both its results
    assign advance   = stage_valid_reg && room2;
    assign pkt.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (pkt.ready)
        begin
            stage_valid_reg <= pkt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.ready && pkt.valid)
        begin
            stage_item_reg.data_byte      <= pkt.data_byte;
            stage_item_reg.packet_length  <= pkt.packet_length;
            stage_item_reg.from_initiator <= pkt.from_initiator;
            stage_item_reg.last_byte      <= pkt.last_byte;
        end
    end

    kfve_parser #(
        .VERSION_BUFFER (VERSION_BUFFER)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .enable  (advance),
        .item    (stage_item_reg),
        .results (pair)
    );

    kfve_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pair),
        .room2     (room2),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (head)
    );

    assign res.is_status    = head.is_status;
    assign res.version_byte = head.version_byte;
    assign res.verdict      = 2'(head.verdict);
    assign res.packet_done  = head.packet_done;

endmodule

`default_nettype wire

/* rtl/core/kfve_parser.sv */
// Per-byte packet parser: header check, key match, value streaming, verdict.
`default_nettype none

module kfve_parser
    import kfve_pkg::*;
#(
    parameter int unsigned VERSION_BUFFER = VERSION_BUFFER_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   enable,
    input  item_t       item,
    output result_pair_t results
);

    localparam int unsigned VCW = (VERSION_BUFFER > 2) ? $clog2(VERSION_BUFFER) : 1;
    localparam logic [VCW-1:0] VC_LAST = VCW'(VERSION_BUFFER - 2);

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_KEY     = 6'b000010,
        PH_SEP     = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_VERSION = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    logic [15:0]    pos_reg,   pos_next;
    logic [15:0]    lw_reg,    lw_next;
    phase_t         phase_reg, phase_next;
    logic [1:0]     kmc_reg,   kmc_next;
    logic           sep_reg,   sep_next;
    logic [7:0]     held_reg,  held_next;
    logic           hv_reg,    hv_next;
    logic [VCW-1:0] vc_reg,    vc_next;
    verdict_t       pv_reg,    pv_next;

    logic [7:0]  b;
    logic [15:0] len;
    logic        sized;
    logic        pkt_ok;
    logic        key_ok;
    logic        emit_ver;
    verdict_t    final_v;
    result_t     ver_res;
    result_t     stat_res;

    assign b   = item.data_byte;
    assign len = item.packet_length;

    always_comb
    begin
        pos_next   = pos_reg;
        lw_next    = lw_reg;
        phase_next = phase_reg;
        kmc_next   = kmc_reg;
        sep_next   = sep_reg;
        held_next  = held_reg;
        hv_next    = hv_reg;
        vc_next    = vc_reg;
        pv_next    = pv_reg;
        emit_ver   = 1'b0;
        key_ok     = 1'b0;

        // length word capture happens before the check on this same byte
        if (pos_reg == LEN_HI_POS)
        begin
            lw_next = {b, 8'h00};
        end
        else if (pos_reg == LEN_LO_POS)
        begin
            lw_next = {lw_reg[15:8], b};
        end

        sized  = (len >= HDR_LEN) && (lw_next == len - HDR_LEN);
        pkt_ok = item.from_initiator && sized;

        if (phase_reg == PH_HEADER)
        begin
            if (pos_reg >= HDR_LAST_POS)
            begin
                phase_next = PH_KEY;
                kmc_next   = 2'd0;
            end
        end
        else if (pkt_ok && (pos_reg < len))
        begin
            case (phase_reg)
                PH_KEY:
                begin
                    key_ok = (kmc_reg < 2'd3);
                    if ((kmc_reg == 2'd0) && (({1'b0, pos_reg} + 17'd4) > {1'b0, len}))
                    begin
                        key_ok = 1'b0;
                    end
                    if (key_ok && (b == key_char(kmc_reg)))
                    begin
                        kmc_next = kmc_reg + 2'd1;
                        if (kmc_reg == 2'd2)
                        begin
                            pv_next    = VERDICT_SUCCESS;
                            phase_next = PH_SKIP;
                            kmc_next   = 2'd0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_SEP;
                        sep_next   = 1'b0;
                        held_next  = b;
                        hv_next    = 1'b1;
                    end
                end
                PH_SEP:
                begin
                    if (hv_reg && (held_reg == SEP_HI) && (b == SEP_LO))
                    begin
                        hv_next = 1'b0;
                        if (!sep_reg)
                        begin
                            sep_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                            kmc_next   = 2'd0;
                        end
                    end
                    else
                    begin
                        held_next = b;
                        hv_next   = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    kmc_next = kmc_reg + 2'd1;
                    if (kmc_reg >= 2'd1)
                    begin
                        phase_next = PH_VERSION;
                        hv_next    = 1'b0;
                        vc_next    = '0;
                    end
                end
                PH_VERSION:
                begin
                    if (hv_reg)
                    begin
                        if ((held_reg == SEP_HI) && (b == SEP_LO))
                        begin
                            phase_next = PH_DONE;
                            hv_next    = 1'b0;
                        end
                        else
                        begin
                            emit_ver = 1'b1;
                            vc_next  = vc_reg + 1'b1;
                            if (vc_reg >= VC_LAST)
                            begin
                                phase_next = PH_DONE;
                                hv_next    = 1'b0;
                            end
                            else
                            begin
                                held_next = b;
                            end
                        end
                    end
                    else
                    begin
                        held_next = b;
                        hv_next   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 16'd1;
        end

        if (!item.from_initiator)
        begin
            final_v = VERDICT_IN_PROCESS;
        end
        else if (!sized)
        begin
            final_v = VERDICT_REJECT;
        end
        else
        begin
            final_v = pv_next;
        end

        // packet end returns everything to its reset state
        if (item.last_byte)
        begin
            pos_next   = '0;
            lw_next    = '0;
            phase_next = PH_HEADER;
            kmc_next   = '0;
            sep_next   = 1'b0;
            held_next  = '0;
            hv_next    = 1'b0;
            vc_next    = '0;
            pv_next    = VERDICT_IN_PROCESS;
        end
    end

    always_comb
    begin
        ver_res              = '0;
        ver_res.is_status    = 1'b0;
        ver_res.version_byte = held_reg;
        ver_res.verdict      = VERDICT_SUCCESS;

        stat_res             = '0;
        stat_res.is_status   = 1'b1;
        stat_res.verdict     = final_v;
        stat_res.packet_done = 1'b1;

        results = '0;
        if (emit_ver)
        begin
            results.first  = ver_res;
            results.second = stat_res;
            results.count  = item.last_byte ? 2'd2 : 2'd1;
        end
        else
        begin
            results.first  = stat_res;
            results.count  = item.last_byte ? 2'd1 : 2'd0;
        end
        if (!enable)
        begin
            results.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            lw_reg    <= '0;
            phase_reg <= PH_HEADER;
            kmc_reg   <= '0;
            sep_reg   <= 1'b0;
            held_reg  <= '0;
            hv_reg    <= 1'b0;
            vc_reg    <= '0;
            pv_reg    <= VERDICT_IN_PROCESS;
        end
        else if (enable)
        begin
            pos_reg   <= pos_next;
            lw_reg    <= lw_next;
            phase_reg <= phase_next;
            kmc_reg   <= kmc_next;
            sep_reg   <= sep_next;
            held_reg  <= held_next;
            hv_reg    <= hv_next;
            vc_reg    <= vc_next;
            pv_reg    <= pv_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kfve_out_fifo.sv */
// Small result queue: takes up to two results a cycle, delivers one while out_ready is high.
`default_nettype none

module kfve_out_fifo
    import kfve_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  result_pair_t push,
    output logic         room2,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg, wr_next;
    logic [FIFO_AW-1:0]   rd_reg, rd_next;
    logic [FIFO_CW-1:0]   cnt_reg, cnt_next;
    logic                 pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign room2     = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + FIFO_AW'(push.count);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire
